// File: sv/tple_pkg.sv
// Shared types, command codes and CORDIC constants for the turtle pose line engine.
package tple_pkg;

  localparam logic [3:0] CMD_DRAW_FWD  = 4'd0;
  localparam logic [3:0] CMD_DRAW_BACK = 4'd1;
  localparam logic [3:0] CMD_LEFT      = 4'd2;
  localparam logic [3:0] CMD_RIGHT     = 4'd3;
  localparam logic [3:0] CMD_MOVE_FWD  = 4'd4;
  localparam logic [3:0] CMD_MOVE_BACK = 4'd5;
  localparam logic [3:0] CMD_RESET     = 4'd6;
  localparam logic [3:0] CMD_COLOUR    = 4'd7;
  localparam logic [3:0] CMD_HOME      = 4'd8;

  // CORDIC gain correction 0.60725293 in Q0.24, kept signed for the multiplier.
  localparam logic signed [24:0] GAIN_Q24 = 25'sd10188014;
  localparam int unsigned        TABLE_LEN = 24;
  // Rotator width: the scaled length stays below 2^48 even after CORDIC growth.
  localparam int unsigned        XW = 50;
  localparam logic [31:0]        HALF_TURN = 32'h8000_0000;
  localparam logic [23:0]        PEN_WHITE = 24'hFF_FFFF;

  typedef struct packed {
    logic [3:0]         cmd;
    logic signed [23:0] distance;
    logic [15:0]        turn_angle;
    logic [7:0]         pen_red;
    logic [7:0]         pen_green;
    logic [7:0]         pen_blue;
  } in_t;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic [7:0]         line_red;
    logic [7:0]         line_green;
    logic [7:0]         line_blue;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ROT,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic accept;
    logic mul;
    logic rot;
    logic fin;
  } ctl_t;

  typedef struct packed {
    logic in_move;
    logic draw_wait;
  } stat_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:    a = 32'h20000000;
      5'd1:    a = 32'h12E4051E;
      5'd2:    a = 32'h09FB385B;
      5'd3:    a = 32'h051111D4;
      5'd4:    a = 32'h028B0D43;
      5'd5:    a = 32'h0145D7E1;
      5'd6:    a = 32'h00A2F61E;
      5'd7:    a = 32'h00517C55;
      5'd8:    a = 32'h0028BE53;
      5'd9:    a = 32'h00145F2F;
      5'd10:   a = 32'h000A2F98;
      5'd11:   a = 32'h000517CC;
      5'd12:   a = 32'h00028BE6;
      5'd13:   a = 32'h000145F3;
      5'd14:   a = 32'h0000A2F9;
      5'd15:   a = 32'h0000517D;
      5'd16:   a = 32'h000028BE;
      5'd17:   a = 32'h0000145F;
      5'd18:   a = 32'h00000A30;
      5'd19:   a = 32'h00000518;
      5'd20:   a = 32'h0000028C;
      5'd21:   a = 32'h00000146;
      5'd22:   a = 32'h000000A3;
      5'd23:   a = 32'h00000051;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

// File: sv/tple_ctrl.sv
// Sequencer for the turtle engine: accept, gain multiply, CORDIC iterations, finish.
module tple_ctrl #(
  parameter int unsigned NSTG = 16,
  parameter int unsigned IW   = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tple_pkg::stat_t   stat,
  output tple_pkg::ctl_t    ctl,
  output logic [IW-1:0]     idx
);
  import tple_pkg::*;

  state_t        state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          last_stage;

  assign last_stage = (idx_r == IW'(NSTG - 1));
  assign idx        = idx_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && stat.in_move) state_nxt = ST_MUL;
      end
      ST_MUL:  state_nxt = ST_ROT;
      ST_ROT: begin
        if (last_stage) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!stat.draw_wait) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    idx_nxt  = idx_r;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        ctl.accept = in_valid;
      end
      ST_MUL: begin
        ctl.mul = 1'b1;
        idx_nxt = '0;
      end
      ST_ROT: begin
        ctl.rot = 1'b1;
        idx_nxt = idx_r + 1'b1;
      end
      ST_FIN: begin
        ctl.fin = !stat.draw_wait;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

// File: sv/tple_datapath.sv
// Pose registers, gain multiplier, shared CORDIC rotator and output register.
module tple_datapath #(
  parameter int unsigned POS_FRAC_BITS = 16,
  parameter int unsigned IW            = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  tple_pkg::in_t   in_data,
  input  tple_pkg::ctl_t  ctl,
  input  logic [IW-1:0]   idx,
  output tple_pkg::stat_t stat,
  output logic            out_valid,
  input  logic            out_ready,
  output tple_pkg::out_t  out_data
);
  import tple_pkg::*;

  localparam int unsigned S = 32 - POS_FRAC_BITS;
  localparam logic signed [XW-1:0] HALF_LSB = XW'(1) <<< (S - 1);

  logic [31:0]          pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic [15:0]          heading_r, heading_nxt;
  logic [23:0]          pen_r, pen_nxt;
  logic                 draw_r, back_r;
  logic signed [23:0]   dist_r;
  logic signed [XW-1:0] x_r, y_r, x_nxt, y_nxt;
  logic [31:0]          z_r, z_nxt;
  logic                 out_valid_r;
  out_t                 out_r;

  logic signed [48:0]   prod;
  logic signed [XW-1:0] prod_ext, xs, ys, rx, ry;
  logic [31:0]          dx, dy, atan_v;
  logic [1:0]           quad;

  assign stat.in_move = in_data.cmd inside {CMD_DRAW_FWD, CMD_DRAW_BACK,
                                            CMD_MOVE_FWD, CMD_MOVE_BACK};
  // A draw cannot finish while the previous segment is still held at the output.
  assign stat.draw_wait = draw_r && out_valid_r && !out_ready;

  assign prod     = dist_r * GAIN_Q24;
  assign prod_ext = {{(XW - 49){prod[48]}}, prod};
  assign quad     = heading_r[15:14];
  assign xs       = x_r >>> idx;
  assign ys       = y_r >>> idx;
  assign atan_v   = atan_entry(5'(idx));
  assign rx       = (x_r + HALF_LSB) >>> S;
  assign ry       = (y_r + HALF_LSB) >>> S;
  assign dx       = rx[31:0];
  assign dy       = ry[31:0];

  always_comb begin
    heading_nxt = heading_r;
    pen_nxt     = pen_r;
    pos_x_nxt   = pos_x_r;
    pos_y_nxt   = pos_y_r;
    if (ctl.accept) begin
      case (in_data.cmd)
        CMD_LEFT:   heading_nxt = heading_r + in_data.turn_angle;
        CMD_RIGHT:  heading_nxt = heading_r - in_data.turn_angle;
        CMD_RESET: begin
          heading_nxt = '0;
          pos_x_nxt   = '0;
          pos_y_nxt   = '0;
        end
        CMD_COLOUR: pen_nxt = {in_data.pen_red, in_data.pen_green, in_data.pen_blue};
        CMD_HOME: begin
          heading_nxt = '0;
          pos_x_nxt   = '0;
          pos_y_nxt   = '0;
          pen_nxt     = PEN_WHITE;
        end
        default: begin
          heading_nxt = heading_r;
        end
      endcase
    end else if (ctl.fin) begin
      pos_x_nxt = back_r ? pos_x_r - dx : pos_x_r + dx;
      pos_y_nxt = back_r ? pos_y_r - dy : pos_y_r + dy;
    end
  end

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    if (ctl.mul) begin
      // Second and third quadrants: negate the length and rotate by a half turn.
      y_nxt = '0;
      if (quad == 2'd1 || quad == 2'd2) begin
        x_nxt = -prod_ext;
        z_nxt = {heading_r, 16'h0000} + HALF_TURN;
      end else begin
        x_nxt = prod_ext;
        z_nxt = {heading_r, 16'h0000};
      end
    end else if (ctl.rot) begin
      if (!z_r[31]) begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - atan_v;
      end else begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + atan_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      heading_r   <= '0;
      pen_r       <= PEN_WHITE;
      out_valid_r <= 1'b0;
    end else begin
      pos_x_r   <= pos_x_nxt;
      pos_y_r   <= pos_y_nxt;
      heading_r <= heading_nxt;
      pen_r     <= pen_nxt;
      if (ctl.fin && draw_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      draw_r <= (in_data.cmd == CMD_DRAW_FWD) || (in_data.cmd == CMD_DRAW_BACK);
      back_r <= (in_data.cmd == CMD_DRAW_BACK) || (in_data.cmd == CMD_MOVE_BACK);
      dist_r <= in_data.distance;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    if (ctl.fin && draw_r) begin
      out_r.start_x    <= pos_x_r;
      out_r.start_y    <= pos_y_r;
      out_r.end_x      <= pos_x_nxt;
      out_r.end_y      <= pos_y_nxt;
      out_r.line_red   <= pen_r[23:16];
      out_r.line_green <= pen_r[15:8];
      out_r.line_blue  <= pen_r[7:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: sv/turtle_pose_line_engine.sv
// Top level of the turtle pose line engine: controller plus datapath.
//
//   channel   direction  handshake             payload
//   in_       input      in_valid / in_ready   tple_pkg::in_t  (one turtle command)
//   out_      output     out_valid / out_ready tple_pkg::out_t (one line segment)
//
// Turn, colour, reset and home commands complete in the cycle they are accepted.
// Moves and draws step through accept, gain multiply, one iteration per cycle of
// the single shared CORDIC rotator, and finish.
// Synchronous active-low reset returns the pose to the origin facing +x, pen white.
// A draw waits in its finish state only while the previous segment is unread.
module turtle_pose_line_engine #(
  parameter int unsigned CORDIC_STAGES = 16,
  parameter int unsigned POS_FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  tple_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output tple_pkg::out_t out_data
);
  import tple_pkg::*;

  localparam int unsigned NSTG = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
  localparam int unsigned IW   = $clog2(NSTG);

  ctl_t          ctl;
  stat_t         stat;
  logic [IW-1:0] idx;

  tple_ctrl #(
    .NSTG (NSTG),
    .IW   (IW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl),
    .idx      (idx)
  );

  tple_datapath #(
    .POS_FRAC_BITS (POS_FRAC_BITS),
    .IW            (IW)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .ctl       (ctl),
    .idx       (idx),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: sv/tple_checker.sv
// Port-level checks for the turtle pose line engine, bound to the top level.
module tple_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input tple_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input tple_pkg::out_t out_data
);
  import tple_pkg::*;

  logic in_acc;
  logic acc_move;

  assign in_acc   = in_valid && in_ready;
  assign acc_move = (in_data.cmd == CMD_DRAW_FWD) || (in_data.cmd == CMD_DRAW_BACK) ||
                    (in_data.cmd == CMD_MOVE_FWD) || (in_data.cmd == CMD_MOVE_BACK);

  // A pending segment holds until the transaction completes.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("segment dropped or changed while stalled");

  // Moves and draws occupy the rotator, so the next cycle cannot accept.
  a_move_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && acc_move |=> !in_ready)
    else $error("input accepted during a CORDIC rotation");

  // Other commands finish at once and leave the input open.
  a_quick_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !acc_move |=> in_ready)
    else $error("single-cycle command stalled the input");

  // A new segment only appears out of a rotation, never from the idle state.
  a_seg_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("segment issued without a rotation");

endmodule

bind turtle_pose_line_engine tple_checker u_tple_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
